// ===== rtl/core/ycps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ycps_pkg;

    // configuration register width and index codes
    localparam int CFG_BITS  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_FILL = 2'd2;

    // fixed point: accumulators carry 17 fraction bits, mid level is doubled
    localparam int FRAC_Q    = 17;
    localparam int MID_SHIFT = 16;

    // q2.16 coefficients, all magnitudes below 2^17
    localparam int KW = 17;

    localparam logic [KW-1:0] K_CB_R = 17'd11058;
    localparam logic [KW-1:0] K_CB_G = 17'd21710;
    localparam logic [KW-1:0] K_CR_G = 17'd27439;
    localparam logic [KW-1:0] K_CR_B = 17'd5329;
    localparam logic [KW-1:0] K_R_CR = 17'd91881;
    localparam logic [KW-1:0] K_G_CB = 17'd22554;
    localparam logic [KW-1:0] K_G_CR = 17'd46802;
    localparam logic [KW-1:0] K_B_CB = 17'd116130;

endpackage

`default_nettype wire

// ===== rtl/core/ycbcr_pansharpen_pixel.sv =====
// Per-pixel YCbCr pan-sharpening. Each transfer on the input channel carries a
// panchromatic sample and an RGB pixel with their validity flags; exactly one
// result follows per pixel, in order. The block takes one pixel per clock unless a
// stalled output has filled the pipe. The input transfer edge loads the first of
// six register stages (chroma products, chroma sums, chroma clamp, inverse
// products, inverse sums, and the clamp/fill output register); each later stage
// then loads in turn until the result sits in the output register. A stalled
// output holds the result; empty stages ahead of the stall keep taking pixels
// until the pipe is full. If either validity flag is clear the three channels
// carry nodata_fill and o_is_nodata is set. Configuration writes are always
// ready and must only be issued while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ycbcr_pansharpen_pixel #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ycps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ycps_pkg::CFG_BITS-1:0]   i_cfg_data,
    // pixel input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]          i_gray_sample,
    input  wire logic                            i_gray_valid,
    input  wire logic [SAMPLE_BITS-1:0]          i_red_in,
    input  wire logic [SAMPLE_BITS-1:0]          i_green_in,
    input  wire logic [SAMPLE_BITS-1:0]          i_blue_in,
    input  wire logic                            i_color_valid,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [SAMPLE_BITS-1:0]          o_red_out,
    output logic      [SAMPLE_BITS-1:0]          o_green_out,
    output logic      [SAMPLE_BITS-1:0]          o_blue_out,
    output logic                                 o_is_nodata
);
    import ycps_pkg::*;

    localparam int S     = SAMPLE_BITS;
    localparam int ACC_W = SAMPLE_BITS + 20;
    localparam int PU_W  = KW + SAMPLE_BITS;
    localparam int D_W   = SAMPLE_BITS + 2;
    localparam int NSTG  = 6;

    // configuration registers
    logic [S-1:0] r_min_level;
    logic [S-1:0] r_max_level;
    logic [S-1:0] r_nodata_fill;
    logic [S:0]   w_mid2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level   <= '0;
            r_max_level   <= '1;
            r_nodata_fill <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_LEVEL:   r_min_level   <= i_cfg_data[S-1:0];
                CFG_MAX_LEVEL:   r_max_level   <= i_cfg_data[S-1:0];
                CFG_NODATA_FILL: r_nodata_fill <= i_cfg_data[S-1:0];
                default: ;
            endcase
        end
    end

    // doubled mid level
    assign w_mid2 = (S+1)'(r_min_level) + (S+1)'(r_max_level) + (S+1)'(1);

    // per-stage advance: a stage loads when it is empty or its successor moves
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_en;

    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || i_out_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: chroma products
    logic          r_s1_ok;
    logic [S-1:0]  r_s1_gy;
    logic [S-1:0]  r_s1_r;
    logic [S-1:0]  r_s1_b;
    logic [PU_W-1:0] r_s1_pcb_r;
    logic [PU_W-1:0] r_s1_pcb_g;
    logic [PU_W-1:0] r_s1_pcr_g;
    logic [PU_W-1:0] r_s1_pcr_b;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_ok    <= i_gray_valid && i_color_valid;
            r_s1_gy    <= i_gray_sample;
            r_s1_r     <= i_red_in;
            r_s1_b     <= i_blue_in;
            r_s1_pcb_r <= PU_W'(K_CB_R) * PU_W'(i_red_in);
            r_s1_pcb_g <= PU_W'(K_CB_G) * PU_W'(i_green_in);
            r_s1_pcr_g <= PU_W'(K_CR_G) * PU_W'(i_green_in);
            r_s1_pcr_b <= PU_W'(K_CR_B) * PU_W'(i_blue_in);
        end
    end

    // stage 2: chroma sums around the mid level
    logic signed [ACC_W-1:0] w_mid_q;
    logic signed [ACC_W-1:0] n_cb_acc;
    logic signed [ACC_W-1:0] n_cr_acc;
    logic                    r_s2_ok;
    logic [S-1:0]            r_s2_gy;
    logic signed [ACC_W-1:0] r_s2_cb_acc;
    logic signed [ACC_W-1:0] r_s2_cr_acc;

    assign w_mid_q = signed'(ACC_W'({w_mid2, {MID_SHIFT{1'b0}}}));

    always_comb begin
        n_cb_acc = w_mid_q
                 - signed'(ACC_W'({r_s1_pcb_r, 1'b0}))
                 - signed'(ACC_W'({r_s1_pcb_g, 1'b0}))
                 + signed'(ACC_W'({r_s1_b, {MID_SHIFT{1'b0}}}));
        n_cr_acc = w_mid_q
                 + signed'(ACC_W'({r_s1_r, {MID_SHIFT{1'b0}}}))
                 - signed'(ACC_W'({r_s1_pcr_g, 1'b0}))
                 - signed'(ACC_W'({r_s1_pcr_b, 1'b0}));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_ok     <= r_s1_ok;
            r_s2_gy     <= r_s1_gy;
            r_s2_cb_acc <= n_cb_acc;
            r_s2_cr_acc <= n_cr_acc;
        end
    end

    // stage 3: clamp chroma and recenter
    logic [S-1:0]          w_cb;
    logic [S-1:0]          w_cr;
    logic                  r_s3_ok;
    logic [S-1:0]          r_s3_gy;
    logic signed [D_W-1:0] r_s3_dcb;
    logic signed [D_W-1:0] r_s3_dcr;

    ycps_clamp #(
        .SAMPLE_BITS (S),
        .ACC_W       (ACC_W)
    ) u_clamp_cb (
        .i_acc   (r_s2_cb_acc),
        .i_lo    (r_min_level),
        .i_hi    (r_max_level),
        .o_value (w_cb)
    );

    ycps_clamp #(
        .SAMPLE_BITS (S),
        .ACC_W       (ACC_W)
    ) u_clamp_cr (
        .i_acc   (r_s2_cr_acc),
        .i_lo    (r_min_level),
        .i_hi    (r_max_level),
        .o_value (w_cr)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_ok  <= r_s2_ok;
            r_s3_gy  <= r_s2_gy;
            r_s3_dcb <= signed'({1'b0, w_cb, 1'b0}) - signed'({1'b0, w_mid2});
            r_s3_dcr <= signed'({1'b0, w_cr, 1'b0}) - signed'({1'b0, w_mid2});
        end
    end

    // stage 4: inverse transform products
    logic                    r_s4_ok;
    logic [S-1:0]            r_s4_gy;
    logic signed [ACC_W-1:0] r_s4_p_r;
    logic signed [ACC_W-1:0] r_s4_p_gb;
    logic signed [ACC_W-1:0] r_s4_p_gr;
    logic signed [ACC_W-1:0] r_s4_p_b;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_ok   <= r_s3_ok;
            r_s4_gy   <= r_s3_gy;
            r_s4_p_r  <= signed'({1'b0, K_R_CR}) * r_s3_dcr;
            r_s4_p_gb <= signed'({1'b0, K_G_CB}) * r_s3_dcb;
            r_s4_p_gr <= signed'({1'b0, K_G_CR}) * r_s3_dcr;
            r_s4_p_b  <= signed'({1'b0, K_B_CB}) * r_s3_dcb;
        end
    end

    // stage 5: new luma plus chroma terms
    logic signed [ACC_W-1:0] w_yq;
    logic                    r_s5_ok;
    logic signed [ACC_W-1:0] r_s5_r_acc;
    logic signed [ACC_W-1:0] r_s5_g_acc;
    logic signed [ACC_W-1:0] r_s5_b_acc;

    assign w_yq = signed'(ACC_W'({r_s4_gy, {FRAC_Q{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_ok    <= r_s4_ok;
            r_s5_r_acc <= w_yq + r_s4_p_r;
            r_s5_g_acc <= w_yq - r_s4_p_gb - r_s4_p_gr;
            r_s5_b_acc <= w_yq + r_s4_p_b;
        end
    end

    // stage 6: clamp channels or substitute the fill
    logic [S-1:0] w_r;
    logic [S-1:0] w_g;
    logic [S-1:0] w_b;
    logic [S-1:0] r_red;
    logic [S-1:0] r_green;
    logic [S-1:0] r_blue;
    logic         r_nodata;

    ycps_clamp #(
        .SAMPLE_BITS (S),
        .ACC_W       (ACC_W)
    ) u_clamp_r (
        .i_acc   (r_s5_r_acc),
        .i_lo    (r_min_level),
        .i_hi    (r_max_level),
        .o_value (w_r)
    );

    ycps_clamp #(
        .SAMPLE_BITS (S),
        .ACC_W       (ACC_W)
    ) u_clamp_g (
        .i_acc   (r_s5_g_acc),
        .i_lo    (r_min_level),
        .i_hi    (r_max_level),
        .o_value (w_g)
    );

    ycps_clamp #(
        .SAMPLE_BITS (S),
        .ACC_W       (ACC_W)
    ) u_clamp_b (
        .i_acc   (r_s5_b_acc),
        .i_lo    (r_min_level),
        .i_hi    (r_max_level),
        .o_value (w_b)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_nodata <= !r_s5_ok;
            r_red    <= r_s5_ok ? w_r : r_nodata_fill;
            r_green  <= r_s5_ok ? w_g : r_nodata_fill;
            r_blue   <= r_s5_ok ? w_b : r_nodata_fill;
        end
    end

    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_is_nodata = r_nodata;

    // an empty output stage means the whole pipe can advance
    a_ready_when_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output stage is empty");

    // fill is applied to all three channels alike
    a_fill_uniform : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_nodata) |->
            (o_red_out == o_green_out && o_green_out == o_blue_out))
        else $error("no-data result with unequal channels");

    // sharpened channels stay inside an ordered clamp range
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_nodata && r_max_level >= r_min_level) |->
            (o_red_out >= r_min_level && o_red_out <= r_max_level &&
             o_green_out >= r_min_level && o_green_out <= r_max_level &&
             o_blue_out >= r_min_level && o_blue_out <= r_max_level))
        else $error("sharpened channel outside clamp range");

endmodule

`default_nettype wire

// ===== rtl/core/ycps_clamp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ycps_clamp #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 36
) (
    input  wire logic signed [ACC_W-1:0]       i_acc,
    input  wire logic        [SAMPLE_BITS-1:0] i_lo,
    input  wire logic        [SAMPLE_BITS-1:0] i_hi,
    output logic             [SAMPLE_BITS-1:0] o_value
);
    import ycps_pkg::*;

    logic signed [ACC_W-1:0] w_lo_q;
    logic signed [ACC_W-1:0] w_hi_q;

    // limits scaled to the accumulator fraction
    assign w_lo_q = signed'(ACC_W'({i_lo, {FRAC_Q{1'b0}}}));
    assign w_hi_q = signed'(ACC_W'({i_hi, {FRAC_Q{1'b0}}}));

    // ceiling test first, so the ceiling wins when both hit
    always_comb begin
        if (i_acc > w_hi_q) begin
            o_value = i_hi;
        end else if (i_acc < w_lo_q) begin
            o_value = i_lo;
        end else begin
            o_value = i_acc[FRAC_Q +: SAMPLE_BITS];
        end
    end

endmodule

`default_nettype wire

// ===== tb/ycps_pixel_checker.sv =====
`timescale 1ns / 1ps

module ycps_pixel_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [ycps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ycps_pkg::CFG_BITS-1:0]   i_cfg_data,
    // pixel input channel
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]          i_gray_sample,
    input  wire logic                            i_gray_valid,
    input  wire logic [SAMPLE_BITS-1:0]          i_red_in,
    input  wire logic [SAMPLE_BITS-1:0]          i_green_in,
    input  wire logic [SAMPLE_BITS-1:0]          i_blue_in,
    input  wire logic                            i_color_valid,
    // result channel
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [SAMPLE_BITS-1:0]          i_red_out,
    input  wire logic [SAMPLE_BITS-1:0]          i_green_out,
    input  wire logic [SAMPLE_BITS-1:0]          i_blue_out,
    input  wire logic                            i_is_nodata,
    // status toward the stimulus side
    output int                                   o_mismatches,
    output int                                   o_pending
);
    import ycps_pkg::*;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red;
        logic [SAMPLE_BITS-1:0] green;
        logic [SAMPLE_BITS-1:0] blue;
        logic                   nodata;
    } t_pixel_result;

    // accumulators carry 17 fraction bits, coefficients are q2.16
    localparam longint ACC_FRAC  = 17;
    localparam longint C_CB_R    = 11058;
    localparam longint C_CB_G    = 21710;
    localparam longint C_HALF    = 32768;
    localparam longint C_CR_G    = 27439;
    localparam longint C_CR_B    = 5329;
    localparam longint C_R_CR    = 91881;
    localparam longint C_G_CB    = 22554;
    localparam longint C_G_CR    = 46802;
    localparam longint C_B_CB    = 116130;

    logic [SAMPLE_BITS-1:0] min_level_q;
    logic [SAMPLE_BITS-1:0] max_level_q;
    logic [SAMPLE_BITS-1:0] fill_q;
    t_pixel_result          expected_pixels[$];

    // floor clamp first, then ceiling clamp, both on the exact fixed-point value
    function automatic longint clamp_level(input longint acc, input longint lo, input longint hi);
        longint v;
        if (acc < (lo <<< ACC_FRAC))
            v = lo;
        else
            v = acc >>> ACC_FRAC;
        if (acc > (hi <<< ACC_FRAC))
            v = hi;
        return v;
    endfunction

    // chroma from rgb, luma from the gray sample, back to rgb
    function automatic t_pixel_result sharpen_pixel(
        input logic [SAMPLE_BITS-1:0] gray,
        input logic                   gray_ok,
        input logic [SAMPLE_BITS-1:0] red,
        input logic [SAMPLE_BITS-1:0] green,
        input logic [SAMPLE_BITS-1:0] blue,
        input logic                   color_ok
    );
        t_pixel_result res;
        longint lo, hi, gy, r, g, b, mid2, cb, cr, dcb, dcr, yq;
        if (!(gray_ok && color_ok)) begin
            res.red    = fill_q;
            res.green  = fill_q;
            res.blue   = fill_q;
            res.nodata = 1'b1;
            return res;
        end
        lo   = min_level_q;
        hi   = max_level_q;
        gy   = gray;
        r    = red;
        g    = green;
        b    = blue;
        mid2 = lo + hi + 1;
        cb   = mid2 * 65536 + 2 * (-C_CB_R * r - C_CB_G * g + C_HALF * b);
        cr   = mid2 * 65536 + 2 * (C_HALF * r - C_CR_G * g - C_CR_B * b);
        cb   = clamp_level(cb, lo, hi);
        cr   = clamp_level(cr, lo, hi);
        dcb  = 2 * cb - mid2;
        dcr  = 2 * cr - mid2;
        yq   = gy <<< ACC_FRAC;
        res.red    = SAMPLE_BITS'(clamp_level(yq + C_R_CR * dcr, lo, hi));
        res.green  = SAMPLE_BITS'(clamp_level(yq - C_G_CB * dcb - C_G_CR * dcr, lo, hi));
        res.blue   = SAMPLE_BITS'(clamp_level(yq + C_B_CB * dcb, lo, hi));
        res.nodata = 1'b0;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [SAMPLE_BITS-1:0] want,
                               input logic [SAMPLE_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    // watch all three channels at the clock edge
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            min_level_q = '0;
            max_level_q = '1;
            fill_q      = '0;
            expected_pixels.delete();
            o_mismatches = 0;
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_LEVEL:   min_level_q = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_MAX_LEVEL:   max_level_q = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_NODATA_FILL: fill_q      = i_cfg_data[SAMPLE_BITS-1:0];
                    default: ;
                endcase
            end
            // result transfer against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t unexpected result: expected none, got %0d %0d %0d %0d",
                             $time, i_red_out, i_green_out, i_blue_out, i_is_nodata);
                    o_mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red_out", want.red, i_red_out);
                    check_field("green_out", want.green, i_green_out);
                    check_field("blue_out", want.blue, i_blue_out);
                    check_field("is_nodata", SAMPLE_BITS'(want.nodata), SAMPLE_BITS'(i_is_nodata));
                end
            end
            // pixel transfer
            if (i_in_valid && i_in_ready)
                expected_pixels.push_back(sharpen_pixel(i_gray_sample, i_gray_valid, i_red_in,
                                                        i_green_in, i_blue_in, i_color_valid));
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== tb/ycbcr_pansharpen_pixel_tb.sv =====
`timescale 1ns / 1ps

module ycbcr_pansharpen_pixel_tb;
    import ycps_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int N_SETTINGS  = 8;
    localparam int N_PHASES    = 4;
    localparam int PHASE_ITEMS = 52;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_MIN_LEVEL;
    logic [CFG_BITS-1:0]    cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] gray_sample = '0;
    logic                   gray_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] red_in = '0;
    logic [SAMPLE_BITS-1:0] green_in = '0;
    logic [SAMPLE_BITS-1:0] blue_in = '0;
    logic                   color_valid = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SAMPLE_BITS-1:0] red_out;
    logic [SAMPLE_BITS-1:0] green_out;
    logic [SAMPLE_BITS-1:0] blue_out;
    logic                   is_nodata;
    int                     mismatches;
    int                     pending;

    // stimulus controls
    int                     in_idle_pct = 0;
    int                     out_stall_pct = 0;
    int                     hold_req = 0;
    int                     hold_ack = 0;
    int                     hold_left = 0;
    int                     cycle_cnt = 0;

    ycbcr_pansharpen_pixel #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_gray_sample (gray_sample),
        .i_gray_valid  (gray_valid),
        .i_red_in      (red_in),
        .i_green_in    (green_in),
        .i_blue_in     (blue_in),
        .i_color_valid (color_valid),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_red_out     (red_out),
        .o_green_out   (green_out),
        .o_blue_out    (blue_out),
        .o_is_nodata   (is_nodata)
    );

    ycps_pixel_checker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_gray_sample (gray_sample),
        .i_gray_valid  (gray_valid),
        .i_red_in      (red_in),
        .i_green_in    (green_in),
        .i_blue_in     (blue_in),
        .i_color_valid (color_valid),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_red_out     (red_out),
        .i_green_out   (green_out),
        .i_blue_out    (blue_out),
        .i_is_nodata   (is_nodata),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result receiver: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // one pixel transfer, with random idle cycles ahead of it
    task automatic send_pixel(input logic [15:0] gray, input logic gval, input logic [15:0] r,
                              input logic [15:0] g, input logic [15:0] b, input logic cval);
        logic got;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        gray_sample <= gray;
        gray_valid  <= gval;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        color_valid <= cval;
        do begin
            @(negedge clk);
            got = in_ready;
            @(posedge clk);
        end while (!got);
    endtask

    // one register write transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        logic got;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(negedge clk);
            got = cfg_ready;
            @(posedge clk);
        end while (!got);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering pixels and wait for every result to come back
    task automatic drain_pixels();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // extremes, range edges, values inside the range, and fully random words
    function automatic logic [15:0] pick_sample(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return lo;
            3:       return hi;
            4, 5:    return 16'($urandom_range(hi, lo));
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] set_lo[N_SETTINGS];
        logic [15:0] set_hi[N_SETTINGS];
        logic [15:0] set_fill[N_SETTINGS];
        int          idle_in[N_PHASES];
        int          idle_out[N_PHASES];

        // register settings: full range, video range, degenerate and inverted ranges
        set_lo   = '{16'd0,     16'd16,    16'd0,     16'd65535, 16'd4096,
                     16'd50000, 16'd65535, 16'd1000};
        set_hi   = '{16'd65535, 16'd235,   16'd0,     16'd65535, 16'd61440,
                     16'd10000, 16'd0,     16'd1001};
        set_fill = '{16'h0000,  16'h8000,  16'hFFFF,  16'h0001,  16'h1234,
                     16'hABCD,  16'h5555,  16'hFFFE};
        idle_in  = '{0, 53, 0, 32};
        idle_out = '{0, 0, 53, 32};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels at the reset register values
        send_pixel(16'h0000, 1, 16'h0000, 16'h0000, 16'h0000, 1);
        send_pixel(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_pixel(16'h0000, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_pixel(16'hFFFF, 1, 16'h0000, 16'h0000, 16'h0000, 1);
        send_pixel(16'h8000, 1, 16'hFFFF, 16'h0000, 16'h0000, 1);
        send_pixel(16'h8000, 1, 16'h0000, 16'hFFFF, 16'h0000, 1);
        send_pixel(16'h8000, 1, 16'h0000, 16'h0000, 16'hFFFF, 1);
        send_pixel(16'hFFFF, 1, 16'hFFFF, 16'h0000, 16'hFFFF, 1);
        send_pixel(16'h0000, 1, 16'h0000, 16'hFFFF, 16'h0000, 1);
        send_pixel(16'hFFFF, 1, 16'h0000, 16'hFFFF, 16'h0000, 1);
        send_pixel(16'h7FFF, 1, 16'h8000, 16'h8000, 16'h8000, 1);
        send_pixel(16'h5555, 1, 16'hAAAA, 16'h5555, 16'hAAAA, 1);
        // invalid pixels: gray missing, color missing, both missing
        send_pixel(16'h1234, 0, 16'h4321, 16'h1111, 16'h2222, 1);
        send_pixel(16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_pixel(16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_pixel(16'h0000, 0, 16'h0000, 16'h0000, 16'h0000, 0);
        drain_pixels();

        // random pixels across register settings and idle profiles
        for (int s = 0; s < N_SETTINGS; s++) begin
            write_reg(CFG_MIN_LEVEL, set_lo[s]);
            write_reg(CFG_MAX_LEVEL, set_hi[s]);
            write_reg(CFG_NODATA_FILL, set_fill[s]);
            for (int p = 0; p < N_PHASES; p++) begin
                in_idle_pct    = idle_in[p];
                out_stall_pct <= idle_out[p];
                // long receiver hold-off while the sender keeps going
                if (p == 0 && (s == 0 || s == 4))
                    hold_req <= hold_req + 1;
                for (int n = 0; n < PHASE_ITEMS; n++) begin
                    send_pixel(pick_sample(set_lo[s], set_hi[s]),
                               ($urandom_range(99) >= 8),
                               pick_sample(set_lo[s], set_hi[s]),
                               pick_sample(set_lo[s], set_hi[s]),
                               pick_sample(set_lo[s], set_hi[s]),
                               ($urandom_range(99) >= 8));
                end
            end
            drain_pixels();
        end

        // let any stray result show up, then give the verdict
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
